>>> rtl/mmpe_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the modular matrix power engine.
// No dependencies; the other rtl files except mmpe_ram refer to it by scoped names.
package mmpe_pkg;

	localparam int EXP_BITS = 63;
	localparam int MOD_BITS = 35;
	localparam int VAL_W    = 36;
	localparam int EXP_IN_W = 63;
	localparam int OUT_W    = 35;
	localparam int SQ_LIMIT = 2 * EXP_BITS + 1;
	localparam int SQ_W     = $clog2(SQ_LIMIT + 1);
	localparam int EXP_W    = (EXP_BITS > SQ_W) ? EXP_BITS : SQ_W;

	localparam int RAM_DEPTH = 64;
	localparam int ADDR_W    = $clog2(RAM_DEPTH);
	localparam int STORE_N   = 12;
	localparam int SIDX_W    = $clog2(STORE_N);

	localparam logic [ADDR_W-1:0] BASE_MAT = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] BASE_VEC = ADDR_W'(9);
	localparam logic [ADDR_W-1:0] BASE_W   = ADDR_W'(16);
	localparam logic [ADDR_W-1:0] BASE_ACC = ADDR_W'(32);
	localparam logic [ADDR_W-1:0] BASE_T   = ADDR_W'(48);

	localparam logic [3:0] MAT_LAST = 4'd8;
	localparam logic [3:0] VEC_LAST = 4'd2;

	localparam logic [MOD_BITS-1:0] MOD_RESET = MOD_BITS'(35'd4294967087);

	localparam int PADDR_W = 4;
	localparam int PDATA_W = 64;
	// register index is bit 3 of the byte address
	localparam logic REG_MODULUS = 1'b0;

	typedef enum logic [1:0] {
		REQ_WR_MAT = 2'd0,
		REQ_WR_VEC = 2'd1,
		REQ_POWER  = 2'd2,
		REQ_APPLY  = 2'd3
	} req_t;

	typedef struct packed {
		logic                start;
		logic                neg;
		logic [MOD_BITS-1:0] a;
		logic [VAL_W-1:0]    b;
		logic [MOD_BITS-1:0] c;
	} mm_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mm_stat_t;

	// offset of entry (row, col) in a 3x3 block
	function automatic logic [ADDR_W-1:0] mat_off(input logic [1:0] row, input logic [1:0] col);
		logic [ADDR_W-1:0] r;
		r = ADDR_W'(row);
		return (r << 1) + r + ADDR_W'(col);
	endfunction

endpackage

>>> rtl/mmpe_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mmpe_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/mmpe_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiply-add: (c + a*b) mod m, optionally negated mod m.
// Depends on mmpe_pkg. One bit of b per cycle, most significant first.
module mmpe_mulmod (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mmpe_pkg::mm_req_t              req,
	input  logic [mmpe_pkg::MOD_BITS-1:0]  m,
	output mmpe_pkg::mm_stat_t             stat,
	output logic [mmpe_pkg::MOD_BITS-1:0]  r
);

	localparam int MB    = mmpe_pkg::MOD_BITS;
	localparam int VW    = mmpe_pkg::VAL_W;
	localparam int CNT_W = $clog2(VW);

	typedef enum logic [1:0] {U_IDLE, U_RUN, U_FIN} ust_t;

	ust_t            st_q;
	logic [MB-1:0]   a_q, c_q, acc_q, res_q;
	logic [VW-1:0]   b_q;
	logic [CNT_W-1:0] cnt_q;
	logic            neg_q, done_q;

	logic [MB:0] m_x, t, t1, u, u1, s, s1, fin_val;

	always_comb begin
		m_x = {1'b0, m};
		t   = {acc_q, 1'b0};
		t1  = (t >= m_x) ? t - m_x : t;
		u   = t1 + (b_q[VW-1] ? {1'b0, a_q} : '0);
		u1  = (u >= m_x) ? u - m_x : u;
		s   = {1'b0, acc_q} + {1'b0, c_q};
		s1  = (s >= m_x) ? s - m_x : s;
		fin_val = (neg_q && (s1 != '0)) ? m_x - s1 : s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= U_IDLE;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			c_q    <= '0;
			acc_q  <= '0;
			neg_q  <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= (st_q == U_FIN);
			unique case (st_q)
				U_IDLE: begin
					if (req.start) begin
						a_q   <= req.a;
						b_q   <= req.b;
						c_q   <= req.c;
						neg_q <= req.neg;
						acc_q <= '0;
						cnt_q <= CNT_W'(VW - 1);
						st_q  <= U_RUN;
					end
				end
				U_RUN: begin
					// double, then add a on a set bit, keeping the residue below m
					acc_q <= u1[MB-1:0];
					b_q   <= b_q << 1;
					if (cnt_q == '0) begin
						st_q <= U_FIN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				U_FIN: begin
					res_q  <= fin_val[MB-1:0];
					st_q   <= U_IDLE;
				end
				default: st_q <= U_IDLE;
			endcase
		end
	end

	assign stat.busy = (st_q != U_IDLE);
	assign stat.done = done_q;
	assign r         = res_q;

endmodule

>>> rtl/mmpe_core.sv
`timescale 1ns / 1ps
// Sequencer of the matrix power engine: entry RAM, serial multiply-add unit,
// program of copy and matrix-product passes, output register. Uses mmpe_pkg,
// mmpe_ram and mmpe_mulmod.
module mmpe_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [mmpe_pkg::MOD_BITS-1:0]        m,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic [3:0]                           entry_index,
	input  logic signed [mmpe_pkg::VAL_W-1:0]    entry_value,
	input  logic [mmpe_pkg::EXP_IN_W-1:0]        exponent,
	input  logic                                 power_mode,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [3:0]                           out_index,
	output logic [mmpe_pkg::OUT_W-1:0]           out_value,
	output logic                                 last
);

	localparam int MB = mmpe_pkg::MOD_BITS;
	localparam int VW = mmpe_pkg::VAL_W;
	localparam int AW = mmpe_pkg::ADDR_W;
	localparam int EW = mmpe_pkg::EXP_W;
	localparam int SW = mmpe_pkg::SIDX_W;

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_CP_RD, S_CP_DAT, S_CP_RUN, S_CP_OUT, S_ID,
		S_MM_RX, S_MM_RY, S_MM_GO, S_MM_RUN
	} st_t;

	typedef enum logic [3:0] {
		P_A0, P_A1, P_A2, P_A3, P_A4, P_A5,
		P_B0, P_B1, P_B2,
		P_C0, P_C1, P_C2, P_C3,
		P_END
	} ph_t;

	typedef enum logic [2:0] {K_NONE, K_COPY, K_MM, K_ID, K_DONE} kind_t;
	typedef enum logic [1:0] {E_HOLD, E_SHR, E_DEC} eop_t;

	typedef struct packed {
		kind_t         kind;
		logic [AW-1:0] src;
		logic [AW-1:0] yb;
		logic [AW-1:0] dst;
		logic          s3;
		logic          d3;
		logic          emit;
		logic          col1;
		logic [3:0]    cnt_last;
		ph_t           nph;
		eop_t          eop;
	} op_t;

	st_t  st_q;
	ph_t  ph_q;
	op_t  op;

	logic [EW-1:0] exp_q;
	logic [AW-1:0] cp_sa_q, cp_da_q, mx_q, my_q, md_q;
	logic          cp_ss3_q, cp_ds3_q, cp_emit_q, col1_q;
	logic [3:0]    cp_i_q, cp_last_q;
	logic [1:0]    mi_q, mj_q, mk_q;
	logic [VW-1:0] xa_q;
	logic [MB-1:0] acc_q;

	logic                  out_valid_q, last_q;
	logic [3:0]            out_index_q;
	logic [mmpe_pkg::OUT_W-1:0] out_value_q;

	logic [mmpe_pkg::STORE_N-1:0] valid_q;
	logic                         rd_zero_s1;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [VW-1:0] wdata, rdata, rdata_eff, mag;

	mmpe_pkg::mm_req_t  ureq;
	mmpe_pkg::mm_stat_t ustat;
	logic [MB-1:0]      ures;

	mmpe_pkg::req_t rq;
	logic           accept, out_free;
	logic [AW-1:0]  x_addr, y_addr, d_addr;
	logic [EW-1:0]  exp_in, exp_sat;
	logic [1:0]     j_last;

	mmpe_ram #(.WIDTH(VW), .DEPTH(mmpe_pkg::RAM_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	mmpe_mulmod u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (ureq),
		.m      (m),
		.stat   (ustat),
		.r      (ures)
	);

	assign rq        = mmpe_pkg::req_t'(req_type);
	assign in_stall  = (st_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign rdata_eff = rd_zero_s1 ? '0 : rdata;
	assign mag       = rdata_eff[VW-1] ? (~rdata_eff + VW'(1)) : rdata_eff;
	assign x_addr    = mx_q + mmpe_pkg::mat_off(mi_q, mk_q);
	assign y_addr    = my_q + mmpe_pkg::mat_off(mk_q, mj_q);
	assign d_addr    = md_q + mmpe_pkg::mat_off(mi_q, mj_q);
	assign j_last    = col1_q ? 2'd0 : 2'd2;
	assign exp_in    = EW'(exponent[mmpe_pkg::EXP_BITS-1:0]);
	assign exp_sat   = (exp_in > EW'(mmpe_pkg::SQ_LIMIT)) ? EW'(mmpe_pkg::SQ_LIMIT) : exp_in;

	// program step for the current phase
	always_comb begin
		op          = '0;
		op.kind     = K_NONE;
		op.nph      = P_END;
		op.eop      = E_HOLD;
		op.cnt_last = mmpe_pkg::MAT_LAST;
		unique case (ph_q)
			P_A0: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_MAT; op.dst = mmpe_pkg::BASE_W;
				op.nph  = P_A1;
			end
			P_A1: begin
				op.kind = K_ID; op.nph = P_A2;
			end
			P_A2: begin
				if (exp_q == '0) begin
					op.kind = K_COPY; op.src = mmpe_pkg::BASE_ACC; op.dst = mmpe_pkg::BASE_MAT;
					op.emit = 1'b1; op.nph = P_END;
				end else if (exp_q[0]) begin
					op.kind = K_MM; op.src = mmpe_pkg::BASE_W; op.yb = mmpe_pkg::BASE_ACC;
					op.dst  = mmpe_pkg::BASE_T; op.nph = P_A3;
				end else begin
					op.nph = P_A4;
				end
			end
			P_A3: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_T; op.dst = mmpe_pkg::BASE_ACC;
				op.nph  = P_A4;
			end
			P_A4: begin
				op.kind = K_MM; op.src = mmpe_pkg::BASE_W; op.yb = mmpe_pkg::BASE_W;
				op.dst  = mmpe_pkg::BASE_T; op.nph = P_A5;
			end
			P_A5: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_T; op.dst = mmpe_pkg::BASE_W;
				op.nph  = P_A2; op.eop = E_SHR;
			end
			P_B0: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_MAT;
				if (exp_q == '0) begin
					// no squaring: emit the stored matrix reduced, keep it as stored
					op.dst = mmpe_pkg::BASE_T; op.emit = 1'b1; op.nph = P_END;
				end else begin
					op.dst = mmpe_pkg::BASE_W; op.nph = P_B1;
				end
			end
			P_B1: begin
				if (exp_q == '0) begin
					op.kind = K_COPY; op.src = mmpe_pkg::BASE_W; op.dst = mmpe_pkg::BASE_MAT;
					op.emit = 1'b1; op.nph = P_END;
				end else begin
					op.kind = K_MM; op.src = mmpe_pkg::BASE_W; op.yb = mmpe_pkg::BASE_W;
					op.dst  = mmpe_pkg::BASE_T; op.nph = P_B2;
				end
			end
			P_B2: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_T; op.dst = mmpe_pkg::BASE_W;
				op.nph  = P_B1; op.eop = E_DEC;
			end
			P_C0: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_MAT; op.dst = mmpe_pkg::BASE_W;
				op.nph  = P_C1;
			end
			P_C1: begin
				// vector laid out as column 0 of the scratch block
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_VEC; op.dst = mmpe_pkg::BASE_T;
				op.d3   = 1'b1; op.cnt_last = mmpe_pkg::VEC_LAST; op.nph = P_C2;
			end
			P_C2: begin
				op.kind = K_MM; op.src = mmpe_pkg::BASE_W; op.yb = mmpe_pkg::BASE_T;
				op.dst  = mmpe_pkg::BASE_ACC; op.col1 = 1'b1; op.nph = P_C3;
			end
			P_C3: begin
				op.kind = K_COPY; op.src = mmpe_pkg::BASE_ACC; op.dst = mmpe_pkg::BASE_VEC;
				op.s3   = 1'b1; op.emit = 1'b1; op.cnt_last = mmpe_pkg::VEC_LAST;
				op.nph  = P_END;
			end
			P_END: begin
				op.kind = K_DONE;
			end
			default: op.kind = K_DONE;
		endcase
	end

	// RAM ports and unit requests; reads and writes never share a state
	always_comb begin
		we    = 1'b0;
		waddr = cp_da_q;
		wdata = VW'(ures);
		raddr = cp_sa_q;
		ureq  = '0;
		unique case (st_q)
			S_IDLE: begin
				wdata = entry_value;
				if (accept && (rq == mmpe_pkg::REQ_WR_MAT) && (entry_index <= mmpe_pkg::MAT_LAST)) begin
					we    = 1'b1;
					waddr = mmpe_pkg::BASE_MAT + AW'(entry_index);
				end else if (accept && (rq == mmpe_pkg::REQ_WR_VEC)
				             && (entry_index <= mmpe_pkg::VEC_LAST)) begin
					we    = 1'b1;
					waddr = mmpe_pkg::BASE_VEC + AW'(entry_index);
				end
			end
			S_CP_DAT: begin
				ureq.start = 1'b1;
				ureq.neg   = rdata_eff[VW-1];
				ureq.a     = MB'(1);
				ureq.b     = mag;
			end
			S_CP_RUN: begin
				we = ustat.done && !cp_emit_q;
			end
			S_CP_OUT: begin
				we = out_free;
			end
			S_ID: begin
				we    = 1'b1;
				waddr = mmpe_pkg::BASE_ACC + AW'(cp_i_q);
				wdata = ((cp_i_q == 4'd0) || (cp_i_q == 4'd4) || (cp_i_q == 4'd8)) ? VW'(1) : '0;
			end
			S_MM_RX: raddr = x_addr;
			S_MM_RY: raddr = y_addr;
			S_MM_GO: begin
				ureq.start = 1'b1;
				ureq.a     = xa_q[MB-1:0];
				ureq.b     = rdata_eff;
				ureq.c     = acc_q;
			end
			S_MM_RUN: begin
				waddr = d_addr;
				we    = ustat.done && (mk_q == 2'd2);
			end
			default: ;
		endcase
	end

	// stored entries read as zero until first written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_zero_s1 <= 1'b0;
		end else begin
			if (we && (waddr < AW'(mmpe_pkg::STORE_N))) begin
				valid_q[waddr[SW-1:0]] <= 1'b1;
			end
			rd_zero_s1 <= (raddr < AW'(mmpe_pkg::STORE_N)) && !valid_q[raddr[SW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			ph_q        <= P_END;
			exp_q       <= '0;
			cp_sa_q     <= '0;
			cp_da_q     <= '0;
			cp_ss3_q    <= 1'b0;
			cp_ds3_q    <= 1'b0;
			cp_emit_q   <= 1'b0;
			cp_i_q      <= '0;
			cp_last_q   <= '0;
			col1_q      <= 1'b0;
			mx_q        <= '0;
			my_q        <= '0;
			md_q        <= '0;
			mi_q        <= '0;
			mj_q        <= '0;
			mk_q        <= '0;
			xa_q        <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
			out_index_q <= '0;
			out_value_q <= '0;
			last_q      <= 1'b0;
		end else begin
			// drop the taken item unless the emitting pass reloads the register
			if (out_valid_q && !out_stall && !((st_q == S_CP_OUT) && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept && (rq == mmpe_pkg::REQ_POWER)) begin
						exp_q <= power_mode ? exp_sat : exp_in;
						ph_q  <= power_mode ? P_B0 : P_A0;
						st_q  <= S_DISP;
					end else if (accept && (rq == mmpe_pkg::REQ_APPLY)) begin
						ph_q <= P_C0;
						st_q <= S_DISP;
					end
				end
				S_DISP: begin
					ph_q <= op.nph;
					unique case (op.eop)
						E_SHR:   exp_q <= exp_q >> 1;
						E_DEC:   exp_q <= exp_q - EW'(1);
						default: ;
					endcase
					unique case (op.kind)
						K_COPY: begin
							cp_sa_q   <= op.src;
							cp_da_q   <= op.dst;
							cp_ss3_q  <= op.s3;
							cp_ds3_q  <= op.d3;
							cp_emit_q <= op.emit;
							cp_last_q <= op.cnt_last;
							cp_i_q    <= '0;
							st_q      <= S_CP_RD;
						end
						K_MM: begin
							mx_q   <= op.src;
							my_q   <= op.yb;
							md_q   <= op.dst;
							col1_q <= op.col1;
							mi_q   <= '0;
							mj_q   <= '0;
							mk_q   <= '0;
							acc_q  <= '0;
							st_q   <= S_MM_RX;
						end
						K_ID: begin
							cp_i_q <= '0;
							st_q   <= S_ID;
						end
						K_DONE:  st_q <= S_IDLE;
						default: ;
					endcase
				end
				S_CP_RD:  st_q <= S_CP_DAT;
				S_CP_DAT: st_q <= S_CP_RUN;
				S_CP_RUN, S_CP_OUT: begin
					if ((st_q == S_CP_RUN) && ustat.done && cp_emit_q) begin
						st_q <= S_CP_OUT;
					end else if (((st_q == S_CP_RUN) && ustat.done) || ((st_q == S_CP_OUT) && out_free)) begin
						if (st_q == S_CP_OUT) begin
							out_valid_q <= 1'b1;
							out_index_q <= cp_i_q;
							out_value_q <= mmpe_pkg::OUT_W'(ures);
							last_q      <= (cp_i_q == cp_last_q);
						end
						// advance to the next entry of the pass
						cp_sa_q <= cp_sa_q + (cp_ss3_q ? AW'(3) : AW'(1));
						cp_da_q <= cp_da_q + (cp_ds3_q ? AW'(3) : AW'(1));
						if (cp_i_q == cp_last_q) begin
							st_q <= S_DISP;
						end else begin
							cp_i_q <= cp_i_q + 4'd1;
							st_q   <= S_CP_RD;
						end
					end
				end
				S_ID: begin
					if (cp_i_q == mmpe_pkg::MAT_LAST) begin
						st_q <= S_DISP;
					end else begin
						cp_i_q <= cp_i_q + 4'd1;
					end
				end
				S_MM_RX: st_q <= S_MM_RY;
				S_MM_RY: begin
					xa_q <= rdata_eff;
					st_q <= S_MM_GO;
				end
				S_MM_GO: st_q <= S_MM_RUN;
				S_MM_RUN: begin
					if (ustat.done) begin
						if (mk_q == 2'd2) begin
							acc_q <= '0;
							mk_q  <= '0;
							if (mj_q == j_last) begin
								mj_q <= '0;
								if (mi_q == 2'd2) begin
									st_q <= S_DISP;
								end else begin
									mi_q <= mi_q + 2'd1;
									st_q <= S_MM_RX;
								end
							end else begin
								mj_q <= mj_q + 2'd1;
								st_q <= S_MM_RX;
							end
						end else begin
							acc_q <= ures;
							mk_q  <= mk_q + 2'd1;
							st_q  <= S_MM_RX;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		ustat.done |-> ((st_q == S_CP_RUN) || (st_q == S_MM_RUN)))
		else $error("multiply-add result arrived outside a wait state");

	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		ureq.start |-> !ustat.busy)
		else $error("multiply-add unit started while busy");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> !ustat.busy)
		else $error("unit busy while sequencer idle");

	a_k_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_MM_RUN) |-> (mk_q != 2'd3))
		else $error("inner product index out of range");

endmodule

>>> rtl/modular_matrix_power_engine.sv
`timescale 1ns / 1ps
// Modular 3x3 matrix power engine: configuration register port and sequencer.
// Depends on mmpe_pkg and mmpe_core.
//
// Items enter on the input channel (in_valid / in_stall) and results leave on
// the output channel (out_valid / out_stall), both accepted when valid is high
// and stall is low. Write-entry items are written as they are accepted and
// give no result. A power item emits nine entries, an apply item three, with
// last on the final one. All arithmetic runs through one bit-serial
// multiply-add unit, which sets the rate. A^n costs a squaring and up to one
// further matrix product per exponent bit, A^(2^e) one matrix product per
// squaring. After the last result enters the output register, the sequencer
// passes through its dispatch state back to idle before it takes the next
// item. A stall on the output holds the register and pauses the emitting
// pass. Reset clears the stored matrix and vector to zero and sets the
// modulus to 4294967087; no clearing pass is needed.
// The modulus register sits at byte address 0 of the port, 64-bit data.
module modular_matrix_power_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mmpe_pkg::PADDR_W-1:0]        paddr,
	input  logic [mmpe_pkg::PDATA_W-1:0]        pwdata,
	output logic [mmpe_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          req_type,
	input  logic [3:0]                          entry_index,
	input  logic signed [mmpe_pkg::VAL_W-1:0]   entry_value,
	input  logic [mmpe_pkg::EXP_IN_W-1:0]       exponent,
	input  logic                                power_mode,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [3:0]                          out_index,
	output logic [mmpe_pkg::OUT_W-1:0]          out_value,
	output logic                                last
);

	localparam int MB = mmpe_pkg::MOD_BITS;

	logic [MB-1:0] modulus_q, m_eff;
	logic          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[3] == mmpe_pkg::REG_MODULUS);
	assign prdata = (paddr[3] == mmpe_pkg::REG_MODULUS) ? mmpe_pkg::PDATA_W'(modulus_q) : '0;
	// moduli below two behave as two
	assign m_eff  = (modulus_q < MB'(2)) ? MB'(2) : modulus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= mmpe_pkg::MOD_RESET;
		end else if (wr_en) begin
			modulus_q <= pwdata[MB-1:0];
		end
	end

	mmpe_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.m           (m_eff),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.exponent    (exponent),
		.power_mode  (power_mode),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_index   (out_index),
		.out_value   (out_value),
		.last        (last)
	);

endmodule

>>> verif/modular_matrix_power_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for modular_matrix_power_engine: entry writes, matrix powers
// and vector applies are checked against a built-in predictor over several moduli.
// Depends on mmpe_pkg and the engine RTL.
module modular_matrix_power_engine_test;

	typedef struct {
		mmpe_pkg::req_t     kind;
		logic [3:0]         idx;
		logic signed [35:0] val;
		logic [62:0]        expo;
		logic               mode;
	} req_item_t;

	typedef struct {
		logic [3:0]  idx;
		logic [34:0] val;
		logic        last;
	} entry_out_t;

	typedef longint mat_t[9];

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [mmpe_pkg::PADDR_W-1:0] paddr = '0;
	logic [mmpe_pkg::PDATA_W-1:0] pwdata = '0;
	logic [mmpe_pkg::PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] req_type = '0;
	logic [3:0] entry_index = '0;
	logic signed [mmpe_pkg::VAL_W-1:0] entry_value = '0;
	logic [mmpe_pkg::EXP_IN_W-1:0] exponent = '0;
	logic power_mode = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [3:0] out_index;
	logic [mmpe_pkg::OUT_W-1:0] out_value;
	logic last;

	modular_matrix_power_engine dut (.*);

	always #5 clk = ~clk;

	// predictor state
	longint     mod_reg = 64'd4294967087;
	longint     mat_q[9];
	longint     vec_q[3];
	req_item_t  pending_items[$];
	entry_out_t expected_entries[$];
	req_item_t  cur;
	int         send_idle_pct = 10;
	int         out_stall_pct = 69;
	int         errors = 0;
	int         entries_checked = 0;
	int         powers_sent = 0, applies_sent = 0, writes_sent = 0;

	function automatic longint reduce_entry(longint x, longint m);
		longint r;
		r = x % m;
		if (r < 0)
			r += m;
		return r;
	endfunction

	function automatic longint mul_mod(longint a, longint b, longint m);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return longint'(p % 128'(m));
	endfunction

	function automatic mat_t mat_mul(mat_t x, mat_t y, longint m);
		mat_t z;
		longint acc;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc = (acc + mul_mod(x[i*3+k], y[k*3+j], m)) % m;
				z[i*3+j] = acc;
			end
		return z;
	endfunction

	task automatic predict_entries(req_item_t it);
		longint m;
		mat_t w, acc;
		logic [62:0] left;
		int sq;
		longint r[3];
		entry_out_t e;
		m = (mod_reg < 2) ? 2 : mod_reg;
		case (it.kind)
			mmpe_pkg::REQ_WR_MAT: if (it.idx < 9) mat_q[it.idx] = longint'(it.val);
			mmpe_pkg::REQ_WR_VEC: if (it.idx < 3) vec_q[it.idx] = longint'(it.val);
			mmpe_pkg::REQ_POWER: begin
				for (int i = 0; i < 9; i++)
					w[i] = reduce_entry(mat_q[i], m);
				if (!it.mode) begin
					for (int i = 0; i < 9; i++)
						acc[i] = (i % 4 == 0) ? 1 : 0;
					left = it.expo;
					while (left != 0) begin
						if (left[0])
							acc = mat_mul(w, acc, m);
						w = mat_mul(w, w, m);
						left = left >> 1;
					end
					for (int i = 0; i < 9; i++)
						mat_q[i] = acc[i];
				end else if (it.expo != 0) begin
					// squaring count saturates
					sq = (it.expo > mmpe_pkg::SQ_LIMIT) ? mmpe_pkg::SQ_LIMIT : int'(it.expo);
					repeat (sq)
						w = mat_mul(w, w, m);
					for (int i = 0; i < 9; i++)
						mat_q[i] = w[i];
				end
				for (int i = 0; i < 9; i++) begin
					e.idx = 4'(i);
					e.val = 35'(reduce_entry(mat_q[i], m));
					e.last = (i == 8);
					expected_entries.push_back(e);
				end
			end
			mmpe_pkg::REQ_APPLY: begin
				for (int i = 0; i < 3; i++) begin
					r[i] = 0;
					for (int j = 0; j < 3; j++)
						r[i] = (r[i] + mul_mod(reduce_entry(mat_q[i*3+j], m),
							reduce_entry(vec_q[j], m), m)) % m;
				end
				for (int i = 0; i < 3; i++) begin
					vec_q[i] = r[i];
					e.idx = 4'(i);
					e.val = 35'(r[i]);
					e.last = (i == 2);
					expected_entries.push_back(e);
				end
			end
		endcase
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				predict_entries(cur);
				case (cur.kind)
					mmpe_pkg::REQ_POWER: powers_sent++;
					mmpe_pkg::REQ_APPLY: applies_sent++;
					default:             writes_sent++;
				endcase
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					cur = pending_items.pop_front();
					in_valid <= 1'b1;
					req_type <= cur.kind;
					entry_index <= cur.idx;
					entry_value <= cur.val;
					exponent <= cur.expo;
					power_mode <= cur.mode;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		entry_out_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_entries.size() == 0) begin
					$display("%0t: unexpected entry idx=%0d value=%0d last=%0b",
						$time, out_index, out_value, last);
					errors++;
				end else begin
					e = expected_entries.pop_front();
					entries_checked++;
					if (out_index !== e.idx || out_value !== e.val || last !== e.last) begin
						$display("%0t: mismatch expected idx=%0d value=%0d last=%0b, got idx=%0d value=%0d last=%0b",
							$time, e.idx, e.val, e.last, out_index, out_value, last);
						errors++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < out_stall_pct);
		end
	end

	function automatic req_item_t make_item(mmpe_pkg::req_t kind, int idx, longint val,
			logic [62:0] expo, logic mode);
		req_item_t it;
		it.kind = kind;
		it.idx = 4'(idx);
		it.val = 36'(val);
		it.expo = expo;
		it.mode = mode;
		return it;
	endfunction

	function automatic longint rand_value();
		longint v;
		v = longint'({$urandom, $urandom}) % 64'sd34359738368;
		if (v < 0)
			v = -v;
		if ($urandom_range(1))
			v = -v;
		if (v == -64'sd34359738368)
			v = 0;
		return v;
	endfunction

	function automatic logic [62:0] rand_wide();
		return 63'({$urandom, $urandom});
	endfunction

	task automatic add_random(int count);
		int n;
		logic [62:0] e;
		n = 0;
		while (n < count) begin
			case ($urandom_range(9))
				0: begin
					// full reload of matrix and vector, then work on it
					for (int i = 0; i < 9; i++)
						pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, i,
							rand_value(), rand_wide(), 1'($urandom)));
					for (int i = 0; i < 3; i++)
						pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC, i,
							rand_value(), rand_wide(), 1'($urandom)));
					n += 12;
				end
				1, 2, 3: begin
					pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT,
						$urandom_range(15), rand_value(), rand_wide(), 1'($urandom)));
					n++;
				end
				4, 5: begin
					pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC,
						$urandom_range(4), rand_value(), rand_wide(), 1'($urandom)));
					n++;
				end
				6, 7: begin
					if ($urandom_range(1)) begin
						e = ($urandom_range(14) == 0) ? 63'($urandom_range(1 << 20))
							: 63'($urandom_range(15));
						pending_items.push_back(make_item(mmpe_pkg::REQ_POWER,
							$urandom_range(15), rand_value(), e, 1'b0));
					end else begin
						e = ($urandom_range(19) == 0) ? 63'($urandom_range(40))
							: 63'($urandom_range(5));
						pending_items.push_back(make_item(mmpe_pkg::REQ_POWER,
							$urandom_range(15), rand_value(), e, 1'b1));
					end
					n++;
				end
				default: begin
					pending_items.push_back(make_item(mmpe_pkg::REQ_APPLY,
						$urandom_range(15), rand_value(), rand_wide(), 1'($urandom)));
					n++;
				end
			endcase
		end
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_entries.size() != 0);
		// writes give no result and may still be in flight
		repeat (20) @(negedge clk);
	endtask

	task automatic write_modulus(longint value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= '0;
		pwdata <= 64'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		mod_reg = value & 64'h7_FFFF_FFFF;
	endtask

	initial begin
		longint maxv;
		maxv = 64'sd34359738367;
		for (int i = 0; i < 9; i++)
			mat_q[i] = 0;
		for (int i = 0; i < 3; i++)
			vec_q[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, ignored indexes, every request and power corner
		pending_items.push_back(make_item(mmpe_pkg::REQ_APPLY, 0, 0, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 0, maxv, '1, 1));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 1, -maxv, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 2, 5, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 3, -1, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 4, 7, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 6, 123456789, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 7, -987654321, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 8, 2, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 9, 99, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 15, -99, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC, 0, maxv, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC, 1, -maxv, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC, 2, 3, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_VEC, 3, 77, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_APPLY, 15, maxv, '1, 1));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 15, maxv, 63'd13, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 0, 0, 63'd3, 1));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 0, 0, '1, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 0, 0, '1, 1));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 0, 0, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_APPLY, 0, 0, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_WR_MAT, 1, -5, 0, 0));
		pending_items.push_back(make_item(mmpe_pkg::REQ_POWER, 0, 0, 0, 1));
		pending_items.push_back(make_item(mmpe_pkg::REQ_APPLY, 0, 0, 0, 0));
		wait_drained();

		write_modulus(2);
		add_random(30);
		wait_drained();

		send_idle_pct = 69;
		out_stall_pct = 10;
		write_modulus(maxv);
		add_random(30);
		wait_drained();

		write_modulus(2 + longint'($urandom_range(32'hFFFF_FFFF)));
		add_random(30);
		wait_drained();

		send_idle_pct = 0;
		out_stall_pct = 0;
		write_modulus(64'd4294967087);
		add_random(30);
		wait_drained();
		repeat (50) @(posedge clk);

		$display("Covered %0d writes, %0d powers, %0d applies; %0d entries checked",
			writes_sent, powers_sent, applies_sent, entries_checked);
		$display("Moduli: reset value, 2, 2^35-1 and a random one; idle and stall mixes");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#2_000_000_000;
		$display("Run timed out");
		$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mmpe_pkg.sv
rtl/mmpe_ram.sv
rtl/mmpe_mulmod.sv
rtl/mmpe_core.sv
rtl/modular_matrix_power_engine.sv
verif/modular_matrix_power_engine_test.sv
